>>> design/latency_histogram_assert.svh
// assertion macros used by the latency histogram rtl
`ifndef LATENCY_HISTOGRAM_ASSERT_SVH
`define LATENCY_HISTOGRAM_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LH_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("latency_histogram: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define LH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("latency_histogram: next-cycle check failed");

`endif

>>> design/lh_pkg.sv
// shared types, widths and constants of the latency histogram
package lh_pkg;

  localparam int NUM_BUCKETS = 1024;
  localparam int BIDX_W      = $clog2(NUM_BUCKETS);
  localparam int USED_W      = BIDX_W + 1;
  localparam int CNT_W       = 32;
  localparam int SUM_W       = 64;
  localparam int SMP_W       = 31;
  localparam int MODE_W      = 2;
  localparam int STAT_W      = 2;
  localparam int DIV_STEPS   = SMP_W;
  localparam int DSTEP_W     = $clog2(DIV_STEPS);
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [SMP_W-1:0]  MIN_START = SMP_W'(999999999);
  localparam logic [USED_W-1:0] BIU_RESET = USED_W'(NUM_BUCKETS);
  localparam logic [SMP_W-1:0]  BW_RESET  = SMP_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_RECORD  = 2'd0,
    MODE_CLEAR   = 2'd1,
    MODE_READ    = 2'd2,
    MODE_SUMMARY = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    REG_BIU = 1'b0,
    REG_BW  = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_RST_SWEEP,
    S_IDLE,
    S_DISPATCH,
    S_START,
    S_DIV,
    S_RMW_WR,
    S_RD_CAP,
    S_CLR_SWEEP,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic stat_upd;
    logic clr_stats;
    logic sweep_wr;
    logic div_start;
    logic ovf_inc;
    logic rd_idx;
    logic wr_inc;
    logic cap_read;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  zero_sample;
    logic  idx_ok;
    logic  div_done;
    logic  bkt_ovf;
    logic  sweep_last;
  } sts_t;

endpackage

>>> design/lh_if.sv
// input and result channel interfaces
interface lh_in_if import lh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SMP_W-1:0]  sample_value;
  logic [BIDX_W-1:0] bucket_index;

  modport source (output valid, mode, sample_value, bucket_index, input ready);
  modport sink   (input valid, mode, sample_value, bucket_index, output ready);
endinterface

interface lh_out_if import lh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  bucket_count;
  logic [CNT_W-1:0]  overflow_count;
  logic [SMP_W-1:0]  min_sample;
  logic [SMP_W-1:0]  max_sample;
  logic [CNT_W-1:0]  sample_total;
  logic [SUM_W-1:0]  sample_sum;
  logic [SMP_W-1:0]  mean_sample;
  logic [STAT_W-1:0] status;

  modport source (output valid, bucket_count, overflow_count, min_sample, max_sample,
                  sample_total, sample_sum, mean_sample, status, input ready);
  modport sink   (input valid, bucket_count, overflow_count, min_sample, max_sample,
                  sample_total, sample_sum, mean_sample, status, output ready);
endinterface

>>> design/latency_histogram.sv
// a record beat passes from accept through dispatch, divider start, 31 serial divider steps,
//   done, bucket write and result load; an overflowing record skips the bucket write
// throughput: one beat at a time, a new beat is taken only once the previous result
//   is loaded; a clear zeroes the 1024-entry bucket ram one entry per cycle
// reset: synchronous active-low; afterwards the same zero sweep runs with
//   in ready low, config writes are taken throughout
module latency_histogram import lh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  lh_in_if.sink             in_ch,
  lh_out_if.source          out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // config registers, word address picks the register
  logic [USED_W-1:0] biu_r;
  logic [SMP_W-1:0]  bw_r;
  logic              cfg_wr;
  reg_idx_t          cfg_sel;

  cmd_t cmd;
  sts_t sts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      biu_r <= BIU_RESET;
      bw_r  <= BW_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_BIU: biu_r <= pwdata[USED_W-1:0];
        REG_BW:  bw_r  <= pwdata[SMP_W-1:0];
        default: biu_r <= biu_r;
      endcase
    end
  end

  // read data decode
  always_comb begin
    unique case (cfg_sel)
      REG_BIU: prdata = CFG_DW'(biu_r);
      REG_BW:  prdata = CFG_DW'(bw_r);
      default: prdata = '0;
    endcase
  end

  // controller: accepts one beat at a time, owns the result valid flag
  lh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: stats, bucket ram, the two serial dividers, result register
  lh_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_ch.mode),
    .in_value       (in_ch.sample_value),
    .in_idx         (in_ch.bucket_index),
    .biu            (biu_r),
    .bw             (bw_r),
    .bucket_count   (out_ch.bucket_count),
    .overflow_count (out_ch.overflow_count),
    .min_sample     (out_ch.min_sample),
    .max_sample     (out_ch.max_sample),
    .sample_total   (out_ch.sample_total),
    .sample_sum     (out_ch.sample_sum),
    .mean_sample    (out_ch.mean_sample),
    .status         (out_ch.status)
  );

`include "latency_histogram_assert.svh"

  // an accepted beat keeps the engine busy for at least the next cycle
`LH_ASSERT_NEXT(a_one_beat, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)

  // once any sample is counted the minimum cannot exceed the maximum
`LH_ASSERT_HOLDS(a_min_le_max, clk, rst_n,
  out_ch.valid && (out_ch.sample_total != '0),
  out_ch.min_sample <= out_ch.max_sample)

  // no samples means no sum and a zero mean
`LH_ASSERT_HOLDS(a_empty_stats, clk, rst_n,
  out_ch.valid && (out_ch.sample_total == '0),
  (out_ch.sample_sum == '0) && (out_ch.mean_sample == '0))

  // a rejected or out-of-range beat never reports a bucket count
`LH_ASSERT_HOLDS(a_err_no_count, clk, rst_n,
  out_ch.valid && (out_ch.status != ST_OK),
  out_ch.bucket_count == '0)

endmodule

>>> design/lh_ram.sv
// generic single-write, single-read ram with registered read
module lh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/lh_div.sv
// restoring serial divider, one quotient bit per cycle
module lh_div import lh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] rem_init,
  input  logic [SMP_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SMP_W-1:0] quotient
);

  logic               busy_r, busy_nxt;
  logic               done_r;
  logic [DSTEP_W-1:0] step_r;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   dvs_r;
  logic [SMP_W-1:0]   q_r, q_nxt;
  logic [CNT_W:0]     trial;
  logic [CNT_W:0]     diff;
  logic               fits;

  // remainder stays below the divisor, so the shifted trial fits 33 bits
  always_comb begin
    trial    = {rem_r, q_r[SMP_W-1]};
    diff     = trial - {1'b0, dvs_r};
    fits     = trial >= {1'b0, dvs_r};
    rem_nxt  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    q_nxt    = {q_r[SMP_W-2:0], fits};
    busy_nxt = busy_r && (step_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= DSTEP_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        busy_r <= busy_nxt;
        step_r <= step_r - DSTEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      dvs_r <= divisor;
      q_r   <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

>>> design/lh_ctrl.sv
// sequencing state machine of the latency histogram
module lh_ctrl import lh_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RST_SWEEP: if (sts.sweep_last) state_nxt = S_IDLE;
      S_IDLE:      if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        unique case (sts.mode)
          MODE_RECORD:  state_nxt = sts.zero_sample ? S_DONE : S_START;
          MODE_CLEAR:   state_nxt = S_CLR_SWEEP;
          MODE_READ:    state_nxt = sts.idx_ok ? S_RD_CAP : S_DONE;
          MODE_SUMMARY: state_nxt = S_DONE;
          default:      state_nxt = S_DONE;
        endcase
      end
      S_START:     state_nxt = S_DIV;
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = sts.bkt_ovf ? S_DONE : S_RMW_WR;
        end
      end
      S_RMW_WR:    state_nxt = S_DONE;
      S_RD_CAP:    state_nxt = S_DONE;
      S_CLR_SWEEP: if (sts.sweep_last) state_nxt = S_DONE;
      S_DONE:      if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_RST_SWEEP: cmd.sweep_wr = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DISPATCH: begin
        unique case (sts.mode)
          MODE_RECORD:  cmd.stat_upd  = !sts.zero_sample;
          MODE_CLEAR:   cmd.clr_stats = 1'b1;
          MODE_READ:    cmd.rd_idx    = sts.idx_ok;
          MODE_SUMMARY: cmd.stat_upd  = 1'b0;
          default:      cmd.stat_upd  = 1'b0;
        endcase
      end
      S_START: cmd.div_start = 1'b1;
      S_DIV: begin
        if (sts.div_done) begin
          cmd.ovf_inc = sts.bkt_ovf;
        end
      end
      S_RMW_WR:    cmd.wr_inc   = 1'b1;
      S_RD_CAP:    cmd.cap_read = 1'b1;
      S_CLR_SWEEP: cmd.sweep_wr = 1'b1;
      S_DONE:      cmd.out_load = out_free;
      default:     cmd          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RST_SWEEP;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> design/lh_dp.sv
// statistics registers, bucket store, dividers and result register
module lh_dp import lh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [SMP_W-1:0]  in_value,
  input  logic [BIDX_W-1:0] in_idx,
  input  logic [USED_W-1:0] biu,
  input  logic [SMP_W-1:0]  bw,
  output logic [CNT_W-1:0]  bucket_count,
  output logic [CNT_W-1:0]  overflow_count,
  output logic [SMP_W-1:0]  min_sample,
  output logic [SMP_W-1:0]  max_sample,
  output logic [CNT_W-1:0]  sample_total,
  output logic [SUM_W-1:0]  sample_sum,
  output logic [SMP_W-1:0]  mean_sample,
  output logic [STAT_W-1:0] status
);

  mode_t             mode_r;
  logic [SMP_W-1:0]  smp_r;
  logic [BIDX_W-1:0] idx_r;
  logic [CNT_W-1:0]  ovf_r;
  logic [SMP_W-1:0]  min_r;
  logic [SMP_W-1:0]  max_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SMP_W-1:0]  mean_r;
  logic [CNT_W-1:0]  bcnt_r;
  logic [BIDX_W-1:0] sweep_r;

  logic [USED_W-1:0] used;
  logic              zero_sample;
  logic              idx_ok;
  logic              sweep_last;
  logic [SUM_W:0]    sum_ext;
  logic              mean_sat;
  logic [SMP_W-1:0]  divw;
  status_t           st;

  logic              bkt_done;
  logic [SMP_W-1:0]  bkt_q;
  logic              mean_done;
  logic [SMP_W-1:0]  mean_q;

  logic              ram_we;
  logic [BIDX_W-1:0] ram_waddr;
  logic [CNT_W-1:0]  ram_wdata;
  logic [BIDX_W-1:0] ram_raddr;
  logic [CNT_W-1:0]  ram_rdata;

  always_comb begin
    used        = (biu > USED_W'(NUM_BUCKETS)) ? USED_W'(NUM_BUCKETS) : biu;
    zero_sample = (smp_r == '0);
    idx_ok      = {1'b0, idx_r} < used;
    sweep_last  = (sweep_r == BIDX_W'(NUM_BUCKETS - 1));
    sum_ext     = {1'b0, sum_r} + (SUM_W + 1)'(smp_r);
    // quotient would reach 2^31 when the upper dividend bits reach the count
    mean_sat    = sum_r[SUM_W-1:SMP_W] >= {1'b0, cnt_r};
    divw        = (bw == '0) ? SMP_W'(1) : bw;
    if ((mode_r == MODE_RECORD) && zero_sample) begin
      st = ST_ZERO;
    end else if ((mode_r == MODE_READ) && !idx_ok) begin
      st = ST_RANGE;
    end else begin
      st = ST_OK;
    end
  end

  // the mean divider starts with the bucket divider unless the mean saturates; both run the same number of steps
  assign sts.mode        = mode_r;
  assign sts.zero_sample = zero_sample;
  assign sts.idx_ok      = idx_ok;
  assign sts.div_done    = bkt_done;
  assign sts.bkt_ovf     = bkt_q >= SMP_W'(used);
  assign sts.sweep_last  = sweep_last;

  lh_div u_bkt_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .rem_init ('0),
    .dividend (smp_r),
    .divisor  ({1'b0, divw}),
    .done     (bkt_done),
    .quotient (bkt_q)
  );

  lh_div u_mean_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start && !mean_sat),
    .rem_init (sum_r[SUM_W-2:SMP_W]),
    .dividend (sum_r[SMP_W-1:0]),
    .divisor  (cnt_r),
    .done     (mean_done),
    .quotient (mean_q)
  );

  // bucket store: zero sweep, read of the requested index, or read-modify-write of the bucket quotient
  always_comb begin
    ram_we    = cmd.sweep_wr || cmd.wr_inc;
    ram_waddr = cmd.sweep_wr ? sweep_r : bkt_q[BIDX_W-1:0];
    ram_wdata = cmd.sweep_wr ? '0
              : ((ram_rdata == '1) ? ram_rdata : ram_rdata + CNT_W'(1));
    ram_raddr = cmd.rd_idx ? idx_r : bkt_q[BIDX_W-1:0];
  end

  lh_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BUCKETS)) u_bkt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      ovf_r   <= '0;
      min_r   <= MIN_START;
      max_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      mean_r  <= '0;
    end else begin
      if (cmd.sweep_wr) begin
        sweep_r <= sweep_last ? '0 : sweep_r + BIDX_W'(1);
      end
      if (cmd.clr_stats) begin
        ovf_r  <= '0;
        min_r  <= MIN_START;
        max_r  <= '0;
        cnt_r  <= '0;
        sum_r  <= '0;
        mean_r <= '0;
      end else begin
        if (cmd.stat_upd) begin
          cnt_r <= (cnt_r == '1) ? cnt_r : cnt_r + CNT_W'(1);
          sum_r <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
          if (smp_r > max_r) max_r <= smp_r;
          if (smp_r < min_r) min_r <= smp_r;
        end
        if (cmd.ovf_inc) begin
          ovf_r <= (ovf_r == '1) ? ovf_r : ovf_r + CNT_W'(1);
        end
        if (cmd.div_start && mean_sat) begin
          mean_r <= '1;
        end else if (mean_done) begin
          mean_r <= mean_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode_t'(in_mode);
      smp_r  <= in_value;
      idx_r  <= in_idx;
      bcnt_r <= '0;
    end else if (cmd.cap_read) begin
      bcnt_r <= ram_rdata;
    end
    if (cmd.out_load) begin
      bucket_count   <= bcnt_r;
      overflow_count <= ovf_r;
      min_sample     <= min_r;
      max_sample     <= max_r;
      sample_total   <= cnt_r;
      sample_sum     <= sum_r;
      mean_sample    <= mean_r;
      status         <= STAT_W'(st);
    end
  end

endmodule

>>> tb/sv/latency_histogram_tb.sv
// self-checking testbench of the latency histogram: directed and random beats
module latency_histogram_tb import lh_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no beat moved on any port before the run is declared hung;
  // covers the reset and clear sweeps and the long receiver hold-off
  localparam int STALL_LIMIT = 6000;
  localparam int HOLD_CYCLES = 300;
  localparam longint unsigned M31 = 64'h7FFF_FFFF;

  // one result beat as the block should present it
  typedef struct {
    bit [CNT_W-1:0] bucket_count;
    bit [CNT_W-1:0] overflow_count;
    bit [SMP_W-1:0] min_sample;
    bit [SMP_W-1:0] max_sample;
    bit [CNT_W-1:0] sample_total;
    bit [SUM_W-1:0] sample_sum;
    bit [SMP_W-1:0] mean_sample;
    status_t        status;
  } hist_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  lh_in_if  in_bus ();
  lh_out_if out_bus ();

  latency_histogram dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // shadow copy of the histogram state and its two registers
  bit [USED_W-1:0] cfg_used;
  bit [SMP_W-1:0]  cfg_width;
  bit [CNT_W-1:0]  slot_count [NUM_BUCKETS];
  bit [CNT_W-1:0]  spill;
  bit [SMP_W-1:0]  low_mark;
  bit [SMP_W-1:0]  high_mark;
  bit [CNT_W-1:0]  tally;
  bit [SUM_W-1:0]  tally_sum;
  bit [BIDX_W-1:0] recent_slot;

  hist_result_t awaited_stats [$];

  int unsigned mismatches;
  int unsigned in_gap_max;
  int unsigned out_stall_max;
  int unsigned hold_req;
  bit          offering;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  function automatic bit [CNT_W-1:0] sat_inc(bit [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void wipe_histogram();
    foreach (slot_count[i]) slot_count[i] = '0;
    spill     = '0;
    low_mark  = MIN_START;
    high_mark = '0;
    tally     = '0;
    tally_sum = '0;
  endfunction

  // apply one operation to the shadow state and return the beat it produces
  function automatic hist_result_t histo_apply(mode_t m, bit [SMP_W-1:0] smp,
                                               bit [BIDX_W-1:0] idx);
    hist_result_t    r;
    longint unsigned used;
    longint unsigned wdt;
    longint unsigned slot;
    longint unsigned mean;
    // register values beyond the store act as the full store
    used = (cfg_used > NUM_BUCKETS) ? NUM_BUCKETS : cfg_used;
    wdt  = (cfg_width == 0) ? 1 : cfg_width;
    mean = 0;
    r.bucket_count = '0;
    r.status       = ST_OK;
    case (m)
      MODE_RECORD: begin
        if (smp == 0) begin
          // zero latency is refused and leaves every statistic alone
          r.status = ST_ZERO;
        end else begin
          slot  = smp / wdt;
          tally = sat_inc(tally);
          tally_sum = (tally_sum > 64'hFFFF_FFFF_FFFF_FFFF - smp) ? '1 : tally_sum + smp;
          if (smp > high_mark) high_mark = smp;
          if (smp < low_mark) low_mark = smp;
          if (slot >= used) begin
            spill = sat_inc(spill);
          end else begin
            slot_count[slot] = sat_inc(slot_count[slot]);
            recent_slot = BIDX_W'(slot);
          end
        end
      end
      MODE_CLEAR: wipe_histogram();
      MODE_READ: begin
        if (idx < used) r.bucket_count = slot_count[idx];
        else r.status = ST_RANGE;
      end
      default: ;
    endcase
    if (tally != 0) begin
      mean = tally_sum / tally;
      if (mean > M31) mean = M31;
    end
    r.overflow_count = spill;
    r.min_sample     = low_mark;
    r.max_sample     = high_mark;
    r.sample_total   = tally;
    r.sample_sum     = tally_sum;
    r.mean_sample    = SMP_W'(mean);
    return r;
  endfunction

  // sample that mostly lands in low buckets, sometimes past the last one,
  // sometimes full-width noise or zero
  function automatic bit [SMP_W-1:0] draw_sample();
    int unsigned     sel;
    longint unsigned wdt;
    longint unsigned used;
    longint unsigned slot;
    longint unsigned s;
    sel  = $urandom_range(0, 99);
    wdt  = (cfg_width == 0) ? 1 : cfg_width;
    used = (cfg_used > NUM_BUCKETS) ? NUM_BUCKETS : cfg_used;
    if (sel < 3) return '0;
    if (sel < 15) return SMP_W'($urandom);
    slot = (sel < 60) ? $urandom_range(0, 15) : $urandom_range(0, int'(used) + 1);
    s = slot * wdt + $urandom_range(0, int'(wdt - 1));
    if (s > M31) s = $urandom;
    return SMP_W'(s);
  endfunction

  // offer one beat after a random gap and record what it should produce
  task automatic send_beat(mode_t m, bit [SMP_W-1:0] smp, bit [BIDX_W-1:0] idx);
    int unsigned gap;
    gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      if (offering) begin
        in_bus.valid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.mode         <= m;
    in_bus.sample_value <= smp;
    in_bus.bucket_index <= idx;
    offering = 1'b1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    awaited_stats.push_back(histo_apply(m, smp, idx));
  endtask

  // stop offering and wait until every awaited result beat has come back
  task automatic wait_results_drained();
    if (offering) begin
      in_bus.valid <= 1'b0;
      offering = 1'b0;
    end
    while (awaited_stats.size() != 0) @(posedge clk);
  endtask

  // apb write followed by a read-back of the same register
  task automatic cfg_write(reg_idx_t r, bit [CFG_DW-1:0] data);
    logic [CFG_DW-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * int'(r));
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (r)
      REG_BIU: cfg_used  = data[USED_W-1:0];
      default: cfg_width = data[SMP_W-1:0];
    endcase
    want = (r == REG_BIU) ? CFG_DW'(cfg_used) : CFG_DW'(cfg_width);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field((r == REG_BIU) ? "readback buckets_in_use" : "readback bucket_width",
                prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // fresh state straight out of reset: empty statistics, both ends of the store
  task automatic test_after_reset();
    send_beat(MODE_SUMMARY, '0, '0);
    send_beat(MODE_READ, '0, '0);
    send_beat(MODE_READ, '1, BIDX_W'(NUM_BUCKETS - 1));
  endtask

  // zero sample, smallest and largest samples, last bucket and first overflow,
  // then a clear that must wipe the counts just built
  task automatic test_record_edges();
    send_beat(MODE_RECORD, '0, '1);
    send_beat(MODE_RECORD, SMP_W'(1), '0);
    send_beat(MODE_RECORD, SMP_W'(NUM_BUCKETS - 1), '0);
    send_beat(MODE_RECORD, SMP_W'(NUM_BUCKETS), '0);
    send_beat(MODE_RECORD, '1, '0);
    send_beat(MODE_RECORD, SMP_W'(5), '0);
    send_beat(MODE_RECORD, SMP_W'(5), '1);
    send_beat(MODE_READ, '0, BIDX_W'(5));
    send_beat(MODE_READ, '0, BIDX_W'(NUM_BUCKETS - 1));
    send_beat(MODE_READ, '0, BIDX_W'(1));
    send_beat(MODE_SUMMARY, '1, '1);
    send_beat(MODE_CLEAR, '1, '1);
    send_beat(MODE_READ, '0, BIDX_W'(5));
    send_beat(MODE_SUMMARY, '0, '0);
  endtask

  // register extremes: no buckets, more buckets than the store, zero width,
  // widest width with a single bucket
  task automatic test_config_extremes();
    wait_results_drained();
    cfg_write(REG_BIU, '0);
    send_beat(MODE_RECORD, SMP_W'(3), '0);
    send_beat(MODE_READ, '0, '0);
    wait_results_drained();
    cfg_write(REG_BIU, CFG_DW'(2047));
    cfg_write(REG_BW, '0);
    send_beat(MODE_RECORD, SMP_W'(NUM_BUCKETS - 1), '0);
    send_beat(MODE_READ, '0, BIDX_W'(NUM_BUCKETS - 1));
    wait_results_drained();
    cfg_write(REG_BIU, CFG_DW'(1));
    cfg_write(REG_BW, CFG_DW'(M31));
    send_beat(MODE_RECORD, '1, '0);
    send_beat(MODE_RECORD, SMP_W'(7), '0);
    send_beat(MODE_READ, '0, '0);
    send_beat(MODE_READ, '0, BIDX_W'(1));
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_backpressure();
    wait_results_drained();
    cfg_write(REG_BIU, CFG_DW'(NUM_BUCKETS));
    cfg_write(REG_BW, CFG_DW'(2));
    in_gap_max = 0;
    hold_req = HOLD_CYCLES;
    repeat (12) send_beat(MODE_RECORD, draw_sample(), BIDX_W'($urandom));
    send_beat(MODE_READ, '0, recent_slot);
    send_beat(MODE_SUMMARY, '0, '0);
    // sender pauses until the backlog has fully drained
    wait_results_drained();
  endtask

  // random mixes of operations, one register setting and idling style per phase
  task automatic test_random_traffic();
    int unsigned     r;
    mode_t           m;
    bit [BIDX_W-1:0] idx;
    bit [CFG_DW-1:0] val;
    for (int phase = 0; phase < 8; phase++) begin
      wait_results_drained();
      val = (phase == 0) ? CFG_DW'(NUM_BUCKETS) : CFG_DW'($urandom_range(1, 2047));
      cfg_write(REG_BIU, ($urandom & ~CFG_DW'(2047)) | val);
      case ($urandom_range(0, 3))
        0: val = CFG_DW'($urandom_range(0, 4));
        1: val = CFG_DW'($urandom_range(1, 100));
        2: val = CFG_DW'($urandom_range(1, 1 << 20));
        default: val = CFG_DW'($urandom) & CFG_DW'(M31);
      endcase
      cfg_write(REG_BW, ($urandom & ~CFG_DW'(M31)) | val);
      // both sides idle, either side alone, or neither
      in_gap_max    = (phase % 4 == 1 || phase % 4 == 3) ? 0 : 11;
      out_stall_max = (phase % 4 >= 2) ? 0 : 11;
      repeat (225) begin
        r = $urandom_range(0, 199);
        if (r == 0) m = MODE_CLEAR;
        else if (r < 120) m = MODE_RECORD;
        else if (r < 170) m = MODE_READ;
        else m = MODE_SUMMARY;
        idx = $urandom_range(0, 1) ? recent_slot : BIDX_W'($urandom);
        send_beat(m, (m == MODE_RECORD) ? draw_sample() : SMP_W'($urandom), idx);
      end
    end
  endtask

  // result receiver: random stall before each beat, long hold-off on request
  initial begin
    int unsigned stall;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req != 0) begin
        stall = hold_req;
        hold_req = 0;
      end else begin
        stall = (out_stall_max == 0) ? 0 : $urandom_range(0, out_stall_max);
      end
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid && hold_req == 0) @(posedge clk);
    end
  end

  // every result beat against the oldest awaited one
  always @(posedge clk) begin : result_check
    hist_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (awaited_stats.size() == 0) begin
        report_mismatch("result beat with nothing awaited", out_bus.status, '0);
      end else begin
        want = awaited_stats.pop_front();
        check_field("bucket_count", out_bus.bucket_count, want.bucket_count);
        check_field("overflow_count", out_bus.overflow_count, want.overflow_count);
        check_field("min_sample", out_bus.min_sample, want.min_sample);
        check_field("max_sample", out_bus.max_sample, want.max_sample);
        check_field("sample_total", out_bus.sample_total, want.sample_total);
        check_field("sample_sum", out_bus.sample_sum, want.sample_sum);
        check_field("mean_sample", out_bus.mean_sample, want.mean_sample);
        check_field("status", out_bus.status, want.status);
      end
    end
  end

  // hang detector: any beat on input, result or config port resets the count
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable && pready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_bus.valid        <= 1'b0;
    in_bus.mode         <= MODE_RECORD;
    in_bus.sample_value <= '0;
    in_bus.bucket_index <= '0;
    offering      = 1'b0;
    mismatches    = 0;
    hold_req      = 0;
    in_gap_max    = 11;
    out_stall_max = 11;
    cfg_used      = BIU_RESET;
    cfg_width     = BW_RESET;
    recent_slot   = '0;
    wipe_histogram();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_record_edges();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();

    wait_results_drained();
    // let any late or spurious beat show up
    repeat (40) @(posedge clk);
    if (mismatches == 0 && awaited_stats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
